[rtl/rdlarq_pkg.sv]
// Shared types, codes and helpers for the radio data link ARQ controller.
package rdlarq_pkg;

    localparam int TX_SLOTS = 16;
    localparam int SLOT_W   = $clog2(TX_SLOTS);
    localparam int MAX_ACT  = 8;
    localparam int CFG_IDX_W = 3;

    // input commands
    localparam logic [3:0] C_POWER_ON  = 4'd0;
    localparam logic [3:0] C_EST_TO    = 4'd1;
    localparam logic [3:0] C_RETRY_TO  = 4'd2;
    localparam logic [3:0] C_ACTIV_TO  = 4'd3;
    localparam logic [3:0] C_ACK_TO    = 4'd4;
    localparam logic [3:0] C_LR_RX     = 4'd5;
    localparam logic [3:0] C_LA_RX     = 4'd6;
    localparam logic [3:0] C_LT_RX     = 4'd7;
    localparam logic [3:0] C_NET_RESET = 4'd8;
    localparam logic [3:0] C_NET_PKT   = 4'd9;
    localparam logic [3:0] C_CREDIT    = 4'd10;

    // output actions
    localparam logic [3:0] A_SEND_LR  = 4'd0;
    localparam logic [3:0] A_SEND_LA  = 4'd1;
    localparam logic [3:0] A_SEND_LT  = 4'd2;
    localparam logic [3:0] A_READY    = 4'd3;
    localparam logic [3:0] A_FAILURE  = 4'd4;
    localparam logic [3:0] A_ACCEPTED = 4'd5;
    localparam logic [3:0] A_REJECTED = 4'd6;
    localparam logic [3:0] A_DELIVER  = 4'd7;
    localparam logic [3:0] A_TSTART   = 4'd8;
    localparam logic [3:0] A_TSTOP    = 4'd9;
    localparam logic [3:0] A_PRESET   = 4'd10;
    localparam logic [3:0] A_FLUSH    = 4'd11;

    // timers
    localparam logic [1:0] T_EST   = 2'd0;
    localparam logic [1:0] T_RETRY = 2'd1;
    localparam logic [1:0] T_ACK   = 2'd2;
    localparam logic [1:0] T_ACTIV = 2'd3;

    // link phases
    localparam logic [1:0] PH_RWAIT = 2'd0;
    localparam logic [1:0] PH_LWAIT = 2'd1;
    localparam logic [1:0] PH_READY = 2'd2;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] R_MAX_LEN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] R_MAX_WIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] R_VERSION = 3'd2;
    localparam logic [CFG_IDX_W-1:0] R_RETRY   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] R_ACTIV   = 3'd4;

    typedef struct packed {
        logic [3:0] action;
        logic [7:0] frame_a;
        logic [7:0] frame_b;
        logic [7:0] frame_c;
        logic [3:0] tx_slot;
        logic [1:0] timer_id;
    } t_act;

    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] waddr;
        logic [7:0]        wdata;
        logic [SLOT_W-1:0] raddr;
    } t_mem_req;

    function automatic logic [7:0] umin(input logic [7:0] a, input logic [7:0] b);
        return (a < b) ? a : b;
    endfunction

    // x within [a, b], wrapping when a > b
    function automatic logic in_range(input logic [7:0] x, input logic [7:0] a,
                                      input logic [7:0] b);
        if (a <= b) return (x >= a) && (x <= b);
        return (x >= a) || (x <= b);
    endfunction

endpackage

[rtl/radio_data_link_arq_controller.sv]
// Top level: link state sequencer, window walks and action output stage.
//
//  port group   dir  beat content
//  s (input)    in   tdata: command[3:0] hdr_a[11:4] hdr_b[19:12] hdr_c[27:20] credit[35:28]
//  m (output)   out  tdata: action, frame_a, frame_b, frame_c, tx_slot, timer_id; tlast
//  cfg          in   write enable, register index, 8-bit data
//
// One event: the beat is captured, the event is decided, then its action beats go out.
// An in-range LA in the ready phase adds a head walk and possibly a rewind walk over the
// slot memory; each slot visited takes a read state and a compare state, as the slot
// memory read is registered. Input is taken only while idle.
// Reset is synchronous; the slot memory holds no reset and is read only where
// written. Output stalls hold the current beat.
module radio_data_link_arq_controller (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // command, hdr_a, hdr_b, hdr_c, credit_value, 4 zero bits
    input  logic [39:0]                       i_s_tdata,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // action, frame_a, frame_b, frame_c, tx_slot, timer_id, 6 zero bits
    output logic [39:0]                       o_m_tdata,
    output logic                              o_m_tlast,
    input  logic                              i_cfg_we,
    input  logic [rdlarq_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [7:0]                        i_cfg_data
);
    import rdlarq_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_HRD  = 3'd1;
    localparam logic [2:0] S_HCMP = 3'd2;
    localparam logic [2:0] S_NRD  = 3'd3;
    localparam logic [2:0] S_NCMP = 3'd4;
    localparam logic [2:0] S_DEC  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    localparam int CNT_W = $clog2(MAX_ACT + 1);
    localparam int IDX_W = $clog2(MAX_ACT);

    // config
    logic [7:0] r_max_len, r_max_win, r_version;
    logic [3:0] r_retry_lim, r_activ_lim;

    // link state
    logic [2:0] r_state;
    logic [1:0] r_phase, n_phase;
    logic [7:0] r_sss, n_sss, r_rss, n_rss, r_txs, n_txs;
    logic [7:0] r_rcr, n_rcr, r_scl, n_scl, r_acked, n_acked, r_saved, n_saved;
    logic [3:0] r_ret, n_ret, r_act, n_act;
    logic [7:0] r_sent_nr, n_sent_nr, r_sent_nk, n_sent_nk;
    logic [7:0] r_got_ns, r_got_nr, r_prev_nr;
    logic       r_luf, n_luf;
    logic [SLOT_W-1:0] r_head, n_head, r_tail, n_tail, r_next, n_next;
    logic       r_hit;

    // captured beat
    logic [3:0] r_cmd;
    logic [7:0] r_a, r_b, r_c, r_cv;

    // action list
    t_act r_list [MAX_ACT];
    t_act n_list [MAX_ACT];
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [IDX_W-1:0] r_idx;

    t_mem_req   mem_req;
    logic [7:0] mem_rdata;
    logic       n_we;

    logic [SLOT_W-1:0] held;
    logic              rewind_go;

    t_act              out_act;

    rdlarq_slot_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    function automatic t_act mk(input logic [3:0] act, input logic [7:0] a,
                                input logic [7:0] b, input logic [7:0] c,
                                input logic [3:0] slot, input logic [1:0] tmr);
        t_act e;
        e.action = act; e.frame_a = a; e.frame_b = b; e.frame_c = c;
        e.tx_slot = slot; e.timer_id = tmr;
        return e;
    endfunction

    assign held = r_tail - r_head;

    assign mem_req.we    = (r_state == S_DEC) && n_we;
    assign mem_req.waddr = r_tail;
    assign mem_req.wdata = r_sss;
    assign mem_req.raddr = (r_state == S_HRD) ? r_head : r_next;

    // rewind needed after the head walk
    assign rewind_go = (r_got_nr != r_sss) && (r_got_nr == r_prev_nr) &&
                       ((r_ret - 4'd1) != 4'd0) && (r_head != r_tail) &&
                       (mem_rdata == r_got_nr);

    // decide: state update and action list for the captured event
    always_comb begin
        logic [CNT_W-1:0] k;
        logic f_lt, f_stop2, f_la, f_start3, f_lr0, f_max, f_fail, f_lrt;
        k = '0;
        f_lt = 1'b0; f_stop2 = 1'b0; f_la = 1'b0; f_start3 = 1'b0;
        f_lr0 = 1'b0; f_max = 1'b0; f_fail = 1'b0; f_lrt = 1'b0;
        n_list = r_list;
        n_phase = r_phase; n_sss = r_sss; n_rss = r_rss; n_txs = r_txs;
        n_rcr = r_rcr; n_scl = r_scl; n_acked = r_acked; n_saved = r_saved;
        n_ret = r_ret; n_act = r_act; n_sent_nr = r_sent_nr; n_sent_nk = r_sent_nk;
        n_luf = r_luf; n_head = r_head; n_tail = r_tail; n_next = r_next;
        n_we = 1'b0;

        case (r_phase)
            PH_RWAIT: begin
                case (r_cmd) inside
                    C_POWER_ON, C_NET_RESET: begin
                        n_list[k[IDX_W-1:0]] = mk(A_PRESET, '0, '0, '0, '0, '0);
                        k = k + 1'b1;
                        f_max = 1'b1; f_lrt = 1'b1;
                    end
                    C_LR_RX: begin
                        f_lr0 = 1'b1; n_phase = PH_LWAIT;
                    end
                    C_EST_TO, C_LA_RX, C_LT_RX: f_lr0 = 1'b1;
                    C_NET_PKT: begin
                        n_list[k[IDX_W-1:0]] = mk(A_REJECTED, '0, '0, '0, '0, '0);
                        k = k + 1'b1;
                    end
                    default: ;
                endcase
            end
            PH_LWAIT: begin
                case (r_cmd) inside
                    C_LR_RX, C_LA_RX: begin
                        if (r_cmd == C_LA_RX || (r_a <= r_max_len && r_b <= r_max_win &&
                                                 r_c <= r_version)) begin
                            n_sss = 8'd1; n_rss = 8'd1; n_rcr = 8'd1; n_scl = '0;
                            n_acked = 8'd1; n_head = '0; n_tail = '0; n_next = '0;
                            n_ret = r_retry_lim; n_act = r_activ_lim;
                            n_list[k[IDX_W-1:0]] = mk(A_FLUSH, '0, '0, '0, '0, '0);
                            k = k + 1'b1;
                            if (r_cmd == C_LA_RX) n_scl = r_b;
                            n_list[k[IDX_W-1:0]] = mk(A_TSTOP, '0, '0, '0, '0, T_EST);
                            k = k + 1'b1;
                            n_sent_nr = n_rss; n_sent_nk = n_rcr;
                            n_list[k[IDX_W-1:0]] = mk(A_SEND_LA, n_rss, n_rcr, '0, '0, '0);
                            k = k + 1'b1;
                            if (r_cmd == C_LA_RX) begin
                                n_list[k[IDX_W-1:0]] = mk(A_READY, '0, '0, '0, '0, '0);
                                k = k + 1'b1;
                            end
                            n_luf = (r_cmd == C_LA_RX);
                            f_start3 = 1'b1;
                            n_phase = PH_READY;
                        end else begin
                            f_lr0 = 1'b1;
                        end
                    end
                    C_EST_TO, C_LT_RX: f_lr0 = 1'b1;
                    C_NET_RESET: begin
                        n_list[k[IDX_W-1:0]] = mk(A_PRESET, '0, '0, '0, '0, '0);
                        k = k + 1'b1;
                        f_max = 1'b1; f_lrt = 1'b1;
                    end
                    C_NET_PKT: begin
                        n_list[k[IDX_W-1:0]] = mk(A_REJECTED, '0, '0, '0, '0, '0);
                        k = k + 1'b1;
                    end
                    default: ;
                endcase
            end
            PH_READY: begin
                case (r_cmd)
                    C_NET_PKT: begin
                        if (r_scl != 8'd0 && held < SLOT_W'(TX_SLOTS - 1)) begin
                            n_list[k[IDX_W-1:0]] = mk(A_ACCEPTED, '0, '0, '0,
                                                      4'(r_tail), '0);
                            k = k + 1'b1;
                            n_we = 1'b1;
                            n_tail = r_tail + 1'b1;
                            n_ret = r_retry_lim;
                            n_txs = r_sss;
                            n_sss = r_sss + 8'd1;
                            n_scl = r_scl - 8'd1;
                            f_lt = 1'b1;
                        end else begin
                            n_list[k[IDX_W-1:0]] = mk(A_REJECTED, '0, '0, '0, '0, '0);
                            k = k + 1'b1;
                        end
                    end
                    C_RETRY_TO: begin
                        n_ret = r_ret - 4'd1;
                        if (n_ret == 4'd0) begin
                            f_max = 1'b1; f_fail = 1'b1; f_lrt = 1'b1;
                        end else begin
                            if (r_next != r_head) n_next = r_next - 1'b1;
                            f_lt = 1'b1;
                        end
                    end
                    C_LA_RX: begin
                        if (!in_range(r_got_nr, r_acked, r_sss)) begin
                            f_max = 1'b1; f_fail = 1'b1; f_lrt = 1'b1;
                        end else begin
                            // head and next already walked
                            n_act = r_activ_lim;
                            n_scl = r_b;
                            if (!r_luf) begin
                                n_luf = 1'b1;
                                n_list[k[IDX_W-1:0]] = mk(A_READY, '0, '0, '0, '0, '0);
                                k = k + 1'b1;
                            end
                            if (r_got_nr == r_sss) begin
                                n_list[k[IDX_W-1:0]] = mk(A_TSTOP, '0, '0, '0, '0, T_RETRY);
                                k = k + 1'b1;
                                n_ret = r_retry_lim;
                                n_acked = r_got_nr;
                            end else if (r_got_nr == r_prev_nr) begin
                                n_ret = r_ret - 4'd1;
                                if (n_ret == 4'd0) begin
                                    f_max = 1'b1; f_fail = 1'b1; f_lrt = 1'b1;
                                end else if (r_head != r_tail && r_hit) begin
                                    n_txs = r_got_nr;
                                    f_lt = 1'b1;
                                end
                            end
                        end
                    end
                    C_LR_RX: begin
                        f_fail = 1'b1; f_lrt = 1'b1;
                    end
                    C_POWER_ON: begin
                        n_list[k[IDX_W-1:0]] = mk(A_PRESET, '0, '0, '0, '0, '0);
                        k = k + 1'b1;
                        f_max = 1'b1; f_fail = 1'b1; f_lrt = 1'b1;
                    end
                    C_NET_RESET: begin
                        n_list[k[IDX_W-1:0]] = mk(A_PRESET, '0, '0, '0, '0, '0);
                        k = k + 1'b1;
                        f_max = 1'b1; f_lrt = 1'b1;
                    end
                    C_LT_RX: begin
                        n_act = r_activ_lim;
                        if (!in_range(r_got_ns, r_sent_nr, r_sent_nr + r_sent_nk)) begin
                            f_max = 1'b1; f_fail = 1'b1; f_lrt = 1'b1;
                        end else if (r_got_ns != r_rss) begin
                            f_stop2 = 1'b1; f_la = 1'b1; f_start3 = 1'b1;
                        end else if (r_rcr != 8'd0) begin
                            n_list[k[IDX_W-1:0]] = mk(A_DELIVER, '0, '0, '0, '0, '0);
                            k = k + 1'b1;
                            n_rss = r_rss + 8'd1;
                            n_rcr = r_rcr - 8'd1;
                            n_saved = n_rcr;
                            if (r_b == 8'd1) begin
                                f_stop2 = 1'b1; f_la = 1'b1; f_start3 = 1'b1;
                            end else begin
                                n_list[k[IDX_W-1:0]] = mk(A_TSTART, '0, '0, '0, '0, T_ACK);
                                k = k + 1'b1;
                            end
                        end else begin
                            n_saved = r_rcr;
                            f_stop2 = 1'b1; f_la = 1'b1; f_start3 = 1'b1;
                        end
                    end
                    C_ACK_TO: begin
                        f_la = 1'b1; f_start3 = 1'b1;
                    end
                    C_ACTIV_TO: begin
                        n_act = r_act - 4'd1;
                        if (n_act == 4'd0) begin
                            f_max = 1'b1; f_fail = 1'b1; f_lrt = 1'b1;
                        end else begin
                            f_stop2 = 1'b1; f_la = 1'b1; f_start3 = 1'b1;
                        end
                    end
                    C_CREDIT: begin
                        n_rcr = umin(r_max_win, r_cv);
                        if (n_rcr > r_saved) begin
                            f_la = 1'b1; f_start3 = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase

        // tail sequences; one event can end in several of these groups, in this order
        if (f_lt) begin
            n_list[k[IDX_W-1:0]] = mk(A_SEND_LT, n_txs, 8'd1, '0, 4'(n_next), '0);
            k = k + 1'b1;
            if (n_next != n_tail) n_next = n_next + 1'b1;
            n_list[k[IDX_W-1:0]] = mk(A_TSTART, '0, '0, '0, '0, T_RETRY);
            k = k + 1'b1;
        end
        if (f_stop2) begin
            n_list[k[IDX_W-1:0]] = mk(A_TSTOP, '0, '0, '0, '0, T_ACK);
            k = k + 1'b1;
        end
        if (f_la) begin
            n_sent_nr = n_rss; n_sent_nk = n_rcr;
            n_list[k[IDX_W-1:0]] = mk(A_SEND_LA, n_rss, n_rcr, '0, '0, '0);
            k = k + 1'b1;
        end
        if (f_start3) begin
            n_list[k[IDX_W-1:0]] = mk(A_TSTART, '0, '0, '0, '0, T_ACTIV);
            k = k + 1'b1;
        end
        if (f_fail) begin
            n_list[k[IDX_W-1:0]] = mk(A_FAILURE, '0, '0, '0, '0, '0);
            k = k + 1'b1;
        end
        if (f_lrt) begin
            n_list[k[IDX_W-1:0]] = mk(A_TSTOP, '0, '0, '0, '0, T_RETRY);
            k = k + 1'b1;
            n_list[k[IDX_W-1:0]] = mk(A_TSTOP, '0, '0, '0, '0, T_ACK);
            k = k + 1'b1;
            n_list[k[IDX_W-1:0]] = mk(A_TSTOP, '0, '0, '0, '0, T_ACTIV);
            k = k + 1'b1;
            n_phase = PH_RWAIT;
        end
        if (f_lr0 || f_lrt) begin
            n_list[k[IDX_W-1:0]] = mk(A_SEND_LR, r_max_len, r_max_win, r_version,
                                      '0, '0);
            k = k + 1'b1;
            n_list[k[IDX_W-1:0]] = mk(A_TSTART, '0, '0, '0, '0, T_EST);
            k = k + 1'b1;
        end
        // agreed parameters are not visible at the ports
        if (f_max) n_list = n_list;
        n_cnt = k;
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= 8'd255; r_max_win <= 8'd8; r_version <= 8'd1;
            r_retry_lim <= 4'd10; r_activ_lim <= 4'd5;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                R_MAX_LEN: r_max_len   <= i_cfg_data;
                R_MAX_WIN: r_max_win   <= i_cfg_data;
                R_VERSION: r_version   <= i_cfg_data;
                R_RETRY:   r_retry_lim <= i_cfg_data[3:0];
                R_ACTIV:   r_activ_lim <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_s_tvalid) begin
            r_cmd <= i_s_tdata[3:0];
            r_a   <= i_s_tdata[11:4];
            r_b   <= i_s_tdata[19:12];
            r_c   <= i_s_tdata[27:20];
            r_cv  <= i_s_tdata[35:28];
        end
        if (r_state == S_HCMP) r_hit <= (mem_rdata == r_got_nr);
        if (r_state == S_DEC) r_list <= n_list;
    end

    // sequencer and link state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_RWAIT;
            r_sss <= '0; r_rss <= '0; r_txs <= '0; r_rcr <= '0; r_scl <= '0;
            r_acked <= '0; r_saved <= '0; r_ret <= '0; r_act <= '0;
            r_sent_nr <= 8'd1; r_sent_nk <= 8'd1;
            r_got_ns <= '0; r_got_nr <= '0; r_prev_nr <= '0; r_luf <= 1'b0;
            r_head <= '0; r_tail <= '0; r_next <= '0;
            r_cnt <= '0; r_idx <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        if (i_s_tdata[3:0] == C_LA_RX) begin
                            r_prev_nr <= r_got_nr;
                            r_got_nr  <= i_s_tdata[11:4];
                        end else if (i_s_tdata[3:0] == C_LT_RX) begin
                            r_got_ns <= i_s_tdata[11:4];
                        end
                        if (r_phase == PH_READY && i_s_tdata[3:0] == C_LA_RX &&
                            in_range(i_s_tdata[11:4], r_acked, r_sss)) begin
                            r_state <= S_HRD;
                        end else begin
                            r_state <= S_DEC;
                        end
                    end
                end
                S_HRD: r_state <= S_HCMP;
                S_HCMP: begin
                    if (r_head != r_next && mem_rdata != r_got_nr) begin
                        r_head  <= r_head + 1'b1;
                        r_state <= S_HRD;
                    end else if (rewind_go) begin
                        r_state <= S_NRD;
                    end else begin
                        r_state <= S_DEC;
                    end
                end
                S_NRD: r_state <= (r_next == r_head) ? S_DEC : S_NCMP;
                S_NCMP: begin
                    if (r_next != r_tail && mem_rdata == r_got_nr) begin
                        r_state <= S_DEC;
                    end else begin
                        r_next  <= r_next - 1'b1;
                        r_state <= S_NRD;
                    end
                end
                S_DEC: begin
                    r_phase <= n_phase; r_sss <= n_sss; r_rss <= n_rss; r_txs <= n_txs;
                    r_rcr <= n_rcr; r_scl <= n_scl; r_acked <= n_acked;
                    r_saved <= n_saved; r_ret <= n_ret; r_act <= n_act;
                    r_sent_nr <= n_sent_nr; r_sent_nk <= n_sent_nk; r_luf <= n_luf;
                    r_head <= n_head; r_tail <= n_tail; r_next <= n_next;
                    r_cnt <= n_cnt;
                    r_idx <= '0;
                    r_state <= (n_cnt != '0) ? S_OUT : S_IDLE;
                end
                S_OUT: begin
                    if (i_m_tready) begin
                        if (o_m_tlast) r_state <= S_IDLE;
                        else r_idx <= r_idx + 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign out_act    = r_list[r_idx];
    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = (r_state == S_OUT);
    assign o_m_tlast  = (CNT_W'(r_idx) == r_cnt - 1'b1);
    // first field in the lowest bits
    assign o_m_tdata  = {6'd0, out_act.timer_id, out_act.tx_slot, out_act.frame_c,
                         out_act.frame_b, out_act.frame_a, out_act.action};

    // assertions
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_tready && o_m_tvalid))
        else $error("input taken while action beats pending");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (r_cnt != '0) && (r_cnt <= CNT_W'(MAX_ACT)))
        else $error("action count out of range");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && o_m_tlast) |=> o_s_tready)
        else $error("not idle after last action");

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HCMP) |-> (held >= (r_next - r_head)))
        else $error("head walk beyond retransmit pointer");

endmodule

[rtl/rdlarq_slot_mem.sv]
// Slot sequence-number store: one write port, one registered read port.
module rdlarq_slot_mem (
    input  logic                  i_clk,
    input  rdlarq_pkg::t_mem_req  i_req,
    output logic [7:0]            o_rdata
);
    import rdlarq_pkg::*;

    logic [7:0] r_mem [TX_SLOTS];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        o_rdata <= r_mem[i_req.raddr];
    end

endmodule

[tb/radio_data_link_arq_controller_tb.sv]
// Testbench for the radio data link ARQ controller: directed and random events checked against a predictor.
module radio_data_link_arq_controller_tb;
    import rdlarq_pkg::*;

    typedef struct packed {
        logic [3:0] act;
        logic [7:0] fa;
        logic [7:0] fb;
        logic [7:0] fc;
        logic [3:0] slot;
        logic [1:0] tmr;
        logic       last;
    } t_link_action;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [39:0] i_s_tdata = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [39:0] o_m_tdata;
    logic        o_m_tlast;
    logic        i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [7:0]  i_cfg_data = '0;

    radio_data_link_arq_controller u_dut (.*);

    always #1 i_clk = ~i_clk;

    // configuration copy
    logic [7:0] cfg_len, cfg_win, cfg_ver;
    logic [3:0] cfg_retry, cfg_activ;

    // link state copy
    logic [1:0] lk_phase;
    logic [7:0] vs, vr, tx_seq, rx_credit, tx_credit, ack_nr, saved_credit;
    logic [3:0] retries, activity;
    logic [7:0] la_nr, la_nk, rx_ns, rx_nr, prev_rx_nr;
    logic       link_up;
    logic [7:0] ag_len, ag_win, ag_ver;
    logic [7:0] slot_seq [TX_SLOTS];
    logic [3:0] w_head, w_tail, w_next;

    t_link_action ev_buf [MAX_ACT];
    int           ev_count;
    t_link_action pending_actions [$];

    int  errors = 0;
    bit  idle_en = 1'b1;
    int  rx_hold = 0;

    function automatic void put(logic [3:0] act, logic [7:0] a, logic [7:0] b, logic [7:0] c,
                                logic [3:0] slot, logic [1:0] tmr);
        if (ev_count < MAX_ACT) ev_buf[ev_count] = '{act, a, b, c, slot, tmr, 1'b0};
        ev_count++;
    endfunction

    function automatic void put_lr();
        put(A_SEND_LR, cfg_len, cfg_win, cfg_ver, 0, 0);
    endfunction

    function automatic void put_la();
        la_nr = vr;
        la_nk = rx_credit;
        put(A_SEND_LA, vr, rx_credit, 0, 0, 0);
    endfunction

    function automatic void put_lt();
        put(A_SEND_LT, tx_seq, 8'd1, 0, w_next, 0);
        if (w_next != w_tail) w_next = w_next + 1'b1;
    endfunction

    function automatic logic [7:0] min8(logic [7:0] a, logic [7:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic bit seq_between(logic [7:0] x, logic [7:0] lo, logic [7:0] hi);
        if (lo <= hi) return x >= lo && x <= hi;
        return x >= lo || x <= hi;
    endfunction

    function automatic void take_max();
        ag_len = cfg_len; ag_win = cfg_win; ag_ver = cfg_ver;
    endfunction

    function automatic void take_min(logic [7:0] a, logic [7:0] b, logic [7:0] c);
        ag_len = min8(a, cfg_len); ag_win = min8(b, cfg_win); ag_ver = min8(c, cfg_ver);
    endfunction

    function automatic void restart_link();
        put(A_TSTOP, 0, 0, 0, 0, T_RETRY);
        put(A_TSTOP, 0, 0, 0, 0, T_ACK);
        put(A_TSTOP, 0, 0, 0, 0, T_ACTIV);
        put_lr();
        put(A_TSTART, 0, 0, 0, 0, T_EST);
    endfunction

    function automatic void link_init();
        vs = 1; vr = 1; rx_credit = 1; tx_credit = 0; ack_nr = 1;
        w_head = 0; w_tail = 0; w_next = 0;
        retries = cfg_retry; activity = cfg_activ;
        put(A_FLUSH, 0, 0, 0, 0, 0);
    endfunction

    function automatic void link_fail();
        take_max();
        put(A_FAILURE, 0, 0, 0, 0, 0);
        restart_link();
        lk_phase = PH_RWAIT;
    endfunction

    function automatic void link_reset();
        put(A_PRESET, 0, 0, 0, 0, 0);
        take_max();
        restart_link();
        lk_phase = PH_RWAIT;
    endfunction

    function automatic void la_in_ready(logic [7:0] b);
        if (!seq_between(rx_nr, ack_nr, vs)) begin
            link_fail();
            return;
        end
        activity = cfg_activ;
        while (w_head != w_next && slot_seq[w_head] != rx_nr) w_head = w_head + 1'b1;
        tx_credit = b;
        if (!link_up) begin
            link_up = 1'b1;
            put(A_READY, 0, 0, 0, 0, 0);
        end
        if (rx_nr == vs) begin
            put(A_TSTOP, 0, 0, 0, 0, T_RETRY);
            retries = cfg_retry;
            ack_nr = rx_nr;
            return;
        end
        if (rx_nr != prev_rx_nr) return;
        retries = retries - 1'b1;
        if (retries == 0) begin
            link_fail();
            return;
        end
        if (w_head != w_tail && slot_seq[w_head] == rx_nr) begin
            tx_seq = rx_nr;
            // walk back to the slot holding the repeated number
            while (w_next != w_head) begin
                if (w_next != w_tail && slot_seq[w_next] == rx_nr) break;
                w_next = w_next - 1'b1;
            end
            put_lt();
            put(A_TSTART, 0, 0, 0, 0, T_RETRY);
        end
    endfunction

    function automatic void lt_in_ready(logic [7:0] b);
        activity = cfg_activ;
        if (!seq_between(rx_ns, la_nr, la_nr + la_nk)) begin
            link_fail();
            return;
        end
        if (rx_ns != vr || rx_credit == 0) begin
            if (rx_ns == vr) saved_credit = rx_credit;
            put(A_TSTOP, 0, 0, 0, 0, T_ACK);
            put_la();
            put(A_TSTART, 0, 0, 0, 0, T_ACTIV);
            return;
        end
        put(A_DELIVER, 0, 0, 0, 0, 0);
        vr = vr + 1'b1;
        rx_credit = rx_credit - 1'b1;
        saved_credit = rx_credit;
        if (b == 8'd1) begin
            put(A_TSTOP, 0, 0, 0, 0, T_ACK);
            put_la();
            put(A_TSTART, 0, 0, 0, 0, T_ACTIV);
        end else begin
            put(A_TSTART, 0, 0, 0, 0, T_ACK);
        end
    endfunction

    function automatic void predict_event(logic [3:0] cmd, logic [7:0] a, logic [7:0] b,
                                          logic [7:0] c, logic [7:0] cv);
        ev_count = 0;
        if (cmd == C_LA_RX) begin
            prev_rx_nr = rx_nr;
            rx_nr = a;
        end else if (cmd == C_LT_RX) begin
            rx_ns = a;
        end
        case (lk_phase)
            PH_RWAIT: begin
                case (cmd)
                    C_POWER_ON, C_NET_RESET: link_reset();
                    C_LR_RX: begin
                        take_min(a, b, c);
                        put_lr();
                        put(A_TSTART, 0, 0, 0, 0, T_EST);
                        lk_phase = PH_LWAIT;
                    end
                    C_EST_TO, C_LA_RX, C_LT_RX: begin
                        put_lr();
                        put(A_TSTART, 0, 0, 0, 0, T_EST);
                    end
                    C_NET_PKT: put(A_REJECTED, 0, 0, 0, 0, 0);
                    default: ;
                endcase
            end
            PH_LWAIT: begin
                case (cmd)
                    C_LR_RX: begin
                        take_min(a, b, c);
                        if (a <= cfg_len && b <= cfg_win && c <= cfg_ver) begin
                            link_init();
                            put(A_TSTOP, 0, 0, 0, 0, T_EST);
                            put_la();
                            link_up = 1'b0;
                            put(A_TSTART, 0, 0, 0, 0, T_ACTIV);
                            lk_phase = PH_READY;
                        end else begin
                            put_lr();
                            put(A_TSTART, 0, 0, 0, 0, T_EST);
                        end
                    end
                    C_LA_RX: begin
                        link_init();
                        tx_credit = b;
                        put(A_TSTOP, 0, 0, 0, 0, T_EST);
                        put_la();
                        put(A_READY, 0, 0, 0, 0, 0);
                        link_up = 1'b1;
                        put(A_TSTART, 0, 0, 0, 0, T_ACTIV);
                        lk_phase = PH_READY;
                    end
                    C_EST_TO, C_LT_RX: begin
                        put_lr();
                        put(A_TSTART, 0, 0, 0, 0, T_EST);
                    end
                    C_NET_RESET: link_reset();
                    C_NET_PKT: put(A_REJECTED, 0, 0, 0, 0, 0);
                    default: ;
                endcase
            end
            PH_READY: begin
                case (cmd)
                    C_NET_PKT: begin
                        if (tx_credit > 0 && 4'(w_tail - w_head) < 4'(TX_SLOTS - 1)) begin
                            put(A_ACCEPTED, 0, 0, 0, w_tail, 0);
                            slot_seq[w_tail] = vs;
                            w_tail = w_tail + 1'b1;
                            retries = cfg_retry;
                            tx_seq = vs;
                            put_lt();
                            vs = vs + 1'b1;
                            tx_credit = tx_credit - 1'b1;
                            put(A_TSTART, 0, 0, 0, 0, T_RETRY);
                        end else begin
                            put(A_REJECTED, 0, 0, 0, 0, 0);
                        end
                    end
                    C_RETRY_TO: begin
                        retries = retries - 1'b1;
                        if (retries == 0) link_fail();
                        else begin
                            if (w_next != w_head) w_next = w_next - 1'b1;
                            put_lt();
                            put(A_TSTART, 0, 0, 0, 0, T_RETRY);
                        end
                    end
                    C_LA_RX: la_in_ready(b);
                    C_LR_RX: begin
                        take_min(a, b, c);
                        put(A_FAILURE, 0, 0, 0, 0, 0);
                        restart_link();
                        lk_phase = PH_RWAIT;
                    end
                    C_POWER_ON: begin
                        put(A_PRESET, 0, 0, 0, 0, 0);
                        take_max();
                        put(A_FAILURE, 0, 0, 0, 0, 0);
                        restart_link();
                        lk_phase = PH_RWAIT;
                    end
                    C_NET_RESET: link_reset();
                    C_LT_RX: lt_in_ready(b);
                    C_ACK_TO: begin
                        put_la();
                        put(A_TSTART, 0, 0, 0, 0, T_ACTIV);
                    end
                    C_ACTIV_TO: begin
                        activity = activity - 1'b1;
                        if (activity == 0) link_fail();
                        else begin
                            put(A_TSTOP, 0, 0, 0, 0, T_ACK);
                            put_la();
                            put(A_TSTART, 0, 0, 0, 0, T_ACTIV);
                        end
                    end
                    C_CREDIT: begin
                        rx_credit = min8(cfg_win, cv);
                        if (rx_credit > saved_credit) begin
                            put_la();
                            put(A_TSTART, 0, 0, 0, 0, T_ACTIV);
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        if (ev_count > MAX_ACT) ev_count = MAX_ACT;
        for (int i = 0; i < ev_count; i++) begin
            if (i == ev_count - 1) ev_buf[i].last = 1'b1;
            pending_actions.push_back(ev_buf[i]);
        end
    endfunction

    task automatic send_ev(logic [3:0] cmd, logic [7:0] a = 0, logic [7:0] b = 0,
                           logic [7:0] c = 0, logic [7:0] cv = 0);
        int gap;
        gap = idle_en ? $urandom_range(0, 19) : 0;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {4'b0, cv, c, b, a, cmd};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        predict_event(cmd, a, b, c, cv);
    endtask

    task automatic stop_sending();
        @(posedge i_clk);
        i_s_tvalid <= 1'b0;
    endtask

    // waits for every predicted beat, then covers events that produce none
    task automatic wait_drained();
        while (pending_actions.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            R_MAX_LEN: cfg_len   = val;
            R_MAX_WIN: cfg_win   = val;
            R_VERSION: cfg_ver   = val;
            R_RETRY:   cfg_retry = val[3:0];
            R_ACTIV:   cfg_activ = val[3:0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic [7:0] len, logic [7:0] win, logic [7:0] ver,
                              logic [3:0] rl, logic [3:0] al);
        cfg_write(R_MAX_LEN, len);
        cfg_write(R_MAX_WIN, win);
        cfg_write(R_VERSION, ver);
        // upper bits are dropped by the 4-bit registers
        cfg_write(R_RETRY, {4'($urandom), rl});
        cfg_write(R_ACTIV, {4'($urandom), al});
    endtask

    // one random event, mostly well formed for the current phase
    task automatic send_random_ev();
        logic [3:0] cmd;
        logic [7:0] a, b, c, cv;
        int p;
        a = 8'($urandom); b = 8'($urandom); c = 8'($urandom); cv = 8'($urandom);
        p = $urandom_range(0, 99);
        if (p < 6) begin
            cmd = 4'($urandom_range(0, 10));
        end else if (lk_phase == PH_RWAIT) begin
            cmd = (p < 80) ? C_LR_RX : 4'($urandom_range(0, 10));
        end else if (lk_phase == PH_LWAIT) begin
            if (p < 55) begin
                cmd = C_LA_RX;
                b = 8'($urandom_range(0, 30));
            end else if (p < 85) begin
                cmd = C_LR_RX;
                a = min8(a, cfg_len); b = min8(b, cfg_win); c = min8(c, cfg_ver);
            end else begin
                cmd = 4'($urandom_range(0, 10));
            end
        end else begin
            if (p < 38) cmd = C_NET_PKT;
            else if (p < 60) begin
                cmd = C_LA_RX;
                case ($urandom_range(0, 3))
                    0: a = vs;
                    1: a = rx_nr;
                    2: a = ack_nr + 8'($urandom_range(0, 8'(vs - ack_nr)));
                    default: ;
                endcase
                if ($urandom_range(0, 3) != 0) b = 8'($urandom_range(0, 20));
            end else if (p < 78) begin
                cmd = C_LT_RX;
                if ($urandom_range(0, 4) != 0) a = vr;
                else if ($urandom_range(0, 1)) a = la_nr + 8'($urandom_range(0, 8'(la_nk)));
                b = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 1));
            end else if (p < 85) cmd = C_CREDIT;
            else if (p < 90) cmd = C_RETRY_TO;
            else if (p < 94) cmd = C_ACK_TO;
            else if (p < 97) cmd = C_ACTIV_TO;
            else cmd = 4'($urandom_range(0, 10));
        end
        send_ev(cmd, a, b, c, cv);
    endtask

    task automatic test_link_setup();
        send_ev(C_POWER_ON);
        send_ev(C_NET_PKT);
        send_ev(C_EST_TO);
        send_ev(C_LA_RX, 8'hFF, 8'hFF);
        send_ev(C_LR_RX, 8'hFF, 8'd8, 8'd1);
        send_ev(C_LR_RX, 8'hFF, 8'hFF, 8'hFF);
        send_ev(C_LT_RX, 8'hAA, 8'h55);
        send_ev(C_ACK_TO);
        send_ev(C_LA_RX, 8'd0, 8'd20);
    endtask

    task automatic test_transfer();
        repeat (3) send_ev(C_NET_PKT);
        send_ev(C_LT_RX, vr, 8'd1);
        send_ev(C_LT_RX, vr, 8'd0);
        send_ev(C_CREDIT, 0, 0, 0, 8'hFF);
        send_ev(C_LT_RX, vr, 8'd0);
        send_ev(C_LT_RX, vr + 8'd3, 8'd1);
        send_ev(C_LT_RX, vr + 8'd100, 8'd1);
    endtask

    task automatic test_retry_and_window();
        send_ev(C_LR_RX, 8'd1, 8'd1, 8'd0);
        send_ev(C_LR_RX, 8'd0, 8'd0, 8'd0);
        send_ev(C_LA_RX, 8'd1, 8'd30);
        repeat (16) send_ev(C_NET_PKT);
        send_ev(C_RETRY_TO);
        send_ev(C_LA_RX, 8'd3, 8'd30);
        send_ev(C_LA_RX, 8'd3, 8'd30);
        send_ev(C_LA_RX, vs, 8'd5);
        send_ev(C_ACK_TO);
        send_ev(C_ACTIV_TO);
        send_ev(C_LA_RX, vs + 8'd50, 8'd5);
    endtask

    task automatic test_resets();
        send_ev(C_LR_RX, 8'd10, 8'd2, 8'd1);
        send_ev(C_LA_RX, 8'd0, 8'd2);
        send_ev(C_POWER_ON);
        send_ev(C_NET_RESET);
    endtask

    task automatic test_random(int n);
        repeat (n) send_random_ev();
    endtask

    task automatic test_config_extremes();
        stop_sending();
        wait_drained();
        set_config(8'd0, 8'd1, 8'd0, 4'd1, 4'd1);
        test_random(40);
        stop_sending();
        wait_drained();
        set_config(8'd255, 8'd255, 8'd255, 4'd15, 4'd15);
        test_random(60);
        stop_sending();
        wait_drained();
        set_config(8'($urandom), 8'($urandom_range(1, 255)), 8'($urandom),
                   4'($urandom_range(1, 15)), 4'($urandom_range(1, 15)));
        test_random(40);
        stop_sending();
        wait_drained();
        set_config(8'd255, 8'd8, 8'd1, 4'd3, 4'd2);
    endtask

    task automatic test_backpressure();
        rx_hold = 400;
        idle_en = 1'b0;
        test_random(40);
        idle_en = 1'b1;
        stop_sending();
        wait_drained();
        test_random(20);
    endtask

    // result sink: random stalls, plus one long hold-off on request
    initial begin : result_sink
        int stall;
        t_link_action exp_act;
        @(posedge i_rst_n);
        forever begin
            stall = idle_en ? $urandom_range(0, 19) : 0;
            if (rx_hold > 0) begin
                stall = rx_hold;
                rx_hold = 0;
            end
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            @(posedge i_clk);
            while (!o_m_tvalid) @(posedge i_clk);
            if (pending_actions.size() == 0) begin
                $error("unexpected beat %h last %b", o_m_tdata, o_m_tlast);
                errors++;
            end else begin
                exp_act = pending_actions.pop_front();
                if (o_m_tdata[3:0] !== exp_act.act) begin
                    $error("action exp %0d got %0d", exp_act.act, o_m_tdata[3:0]);
                    errors++;
                end
                if (o_m_tdata[11:4] !== exp_act.fa) begin
                    $error("frame_a exp %0d got %0d", exp_act.fa, o_m_tdata[11:4]);
                    errors++;
                end
                if (o_m_tdata[19:12] !== exp_act.fb) begin
                    $error("frame_b exp %0d got %0d", exp_act.fb, o_m_tdata[19:12]);
                    errors++;
                end
                if (o_m_tdata[27:20] !== exp_act.fc) begin
                    $error("frame_c exp %0d got %0d", exp_act.fc, o_m_tdata[27:20]);
                    errors++;
                end
                if (o_m_tdata[31:28] !== exp_act.slot) begin
                    $error("tx_slot exp %0d got %0d", exp_act.slot, o_m_tdata[31:28]);
                    errors++;
                end
                if (o_m_tdata[33:32] !== exp_act.tmr) begin
                    $error("timer_id exp %0d got %0d", exp_act.tmr, o_m_tdata[33:32]);
                    errors++;
                end
                if (o_m_tlast !== exp_act.last) begin
                    $error("last exp %0d got %0d", exp_act.last, o_m_tlast);
                    errors++;
                end
            end
        end
    end

    initial begin : run_tests
        cfg_len = 8'd255; cfg_win = 8'd8; cfg_ver = 8'd1; cfg_retry = 4'd10; cfg_activ = 4'd5;
        lk_phase = PH_RWAIT;
        vs = 0; vr = 0; tx_seq = 0; rx_credit = 0; tx_credit = 0; ack_nr = 0;
        saved_credit = 0; retries = 0; activity = 0; la_nr = 1; la_nk = 1;
        rx_ns = 0; rx_nr = 0; prev_rx_nr = 0; link_up = 0;
        ag_len = 0; ag_win = 0; ag_ver = 0;
        w_head = 0; w_tail = 0; w_next = 0;
        for (int i = 0; i < TX_SLOTS; i++) slot_seq[i] = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_link_setup();
        test_transfer();
        test_retry_and_window();
        test_resets();
        test_random(120);
        test_backpressure();
        test_config_extremes();
        test_random(80);
        stop_sending();
        wait_drained();
        if (errors == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end

    initial begin : watchdog
        #4000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

[files.f]
rtl/rdlarq_pkg.sv
rtl/rdlarq_slot_mem.sv
rtl/radio_data_link_arq_controller.sv
tb/radio_data_link_arq_controller_tb.sv
